// File: sv/pfi_pkg.sv
`default_nettype none
package pfi_pkg;

  localparam int unsigned NUM_CHAN          = 3;
  localparam int unsigned DIV_BITS_PER_STG  = 2;
  localparam int unsigned QUOT_W            = 8;
  localparam int unsigned DIV_STAGES        = QUOT_W / DIV_BITS_PER_STG;
  localparam int unsigned CFG_ADDR_W        = 5;

  localparam logic [2:0] REG_TARGET_RED   = 3'd0;
  localparam logic [2:0] REG_TARGET_GREEN = 3'd1;
  localparam logic [2:0] REG_TARGET_BLUE  = 3'd2;
  localparam logic [2:0] REG_FIRST_INDEX  = 3'd3;
  localparam logic [2:0] REG_LAST_INDEX   = 3'd4;
  localparam logic [2:0] REG_STEP_COUNT   = 3'd5;

  typedef struct packed {
    logic [7:0] entry_index;
    logic [7:0] orig_red;
    logic [7:0] orig_green;
    logic [7:0] orig_blue;
    logic [7:0] step_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_index;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
  } out_item_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][5:0] target;
    logic [7:0]               first_index;
    logic [7:0]               last_index;
    logic [7:0]               step_count;
  } cfg_t;

  // rem holds the partial remainder, wrk the unused dividend bits with
  // quotient bits shifted in from the bottom
  typedef struct packed {
    logic [7:0] orig;
    logic       neg;
    logic [7:0] rem;
    logic [7:0] wrk;
  } chan_t;

  typedef struct packed {
    logic [7:0]               idx;
    logic                     fin;
    logic                     hit;
    logic [NUM_CHAN-1:0]      unused_pad;
    chan_t [NUM_CHAN-1:0]     ch;
  } div_item_t;

  // v*255/63 == 4*v + v/21 exactly for a six-bit v
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] frac;
    frac = (v == 6'd63) ? 2'd3 :
           ((v >= 6'd42) ? 2'd2 : ((v >= 6'd21) ? 2'd1 : 2'd0));
    return {v, 2'b00} + {6'd0, frac};
  endfunction

endpackage
`default_nettype wire

// File: sv/pfi_regs.sv
`default_nettype none
module pfi_regs
  import pfi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_TARGET_RED:   cfg_nxt.target[0]   = cfg_pwdata[5:0];
        REG_TARGET_GREEN: cfg_nxt.target[1]   = cfg_pwdata[5:0];
        REG_TARGET_BLUE:  cfg_nxt.target[2]   = cfg_pwdata[5:0];
        REG_FIRST_INDEX:  cfg_nxt.first_index = cfg_pwdata[7:0];
        REG_LAST_INDEX:   cfg_nxt.last_index  = cfg_pwdata[7:0];
        REG_STEP_COUNT:   cfg_nxt.step_count  = cfg_pwdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TARGET_RED:   cfg_prdata = {26'd0, cfg_r.target[0]};
      REG_TARGET_GREEN: cfg_prdata = {26'd0, cfg_r.target[1]};
      REG_TARGET_BLUE:  cfg_prdata = {26'd0, cfg_r.target[2]};
      REG_FIRST_INDEX:  cfg_prdata = {24'd0, cfg_r.first_index};
      REG_LAST_INDEX:   cfg_prdata = {24'd0, cfg_r.last_index};
      REG_STEP_COUNT:   cfg_prdata = {24'd0, cfg_r.step_count};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target      <= '0;
      cfg_r.first_index <= 8'd0;
      cfg_r.last_index  <= 8'd255;
      cfg_r.step_count  <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/pfi_prep.sv
`default_nettype none
module pfi_prep
  import pfi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output div_item_t      out_data
);

  logic      valid_r;
  div_item_t data_r;
  div_item_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [NUM_CHAN-1:0][7:0] orig;
    logic [7:0]               tgt;
    logic [7:0]               mag;
    logic [15:0]              prod;
    orig[0] = in_data.orig_red;
    orig[1] = in_data.orig_green;
    orig[2] = in_data.orig_blue;
    data_nxt.idx        = in_data.entry_index;
    data_nxt.fin        = in_data.step_number >= cfg.step_count;
    data_nxt.hit        = (in_data.entry_index >= cfg.first_index) &&
                          (in_data.entry_index <= cfg.last_index);
    data_nxt.unused_pad = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      tgt  = widen6(cfg.target[c]);
      data_nxt.ch[c].orig = orig[c];
      data_nxt.ch[c].neg  = tgt < orig[c];
      mag  = (tgt < orig[c]) ? (orig[c] - tgt) : (tgt - orig[c]);
      prod = 16'(mag) * 16'(in_data.step_number);
      // upper half is already below the divisor since step < count
      data_nxt.ch[c].rem  = prod[15:8];
      data_nxt.ch[c].wrk  = prod[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/pfi_div_stage.sv
`default_nettype none
module pfi_div_stage
  import pfi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] divisor,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire div_item_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output div_item_t       out_data
);

  logic      valid_r;
  div_item_t data_r;
  div_item_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [8:0] trial;
    logic       qbit;
    data_nxt = in_data;
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int s = 0; s < DIV_BITS_PER_STG; s++) begin
        trial = {data_nxt.ch[c].rem, data_nxt.ch[c].wrk[7]};
        qbit  = trial >= {1'b0, divisor};
        if (qbit) begin
          trial = trial - {1'b0, divisor};
        end
        data_nxt.ch[c].rem = trial[7:0];
        data_nxt.ch[c].wrk = {data_nxt.ch[c].wrk[6:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/pfi_finish.sv
`default_nettype none
module pfi_finish
  import pfi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_item_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      valid_r;
  out_item_t data_r;
  out_item_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [NUM_CHAN-1:0][7:0] res;
    logic [7:0]               tgt;
    logic [7:0]               blended;
    for (int c = 0; c < NUM_CHAN; c++) begin
      tgt     = widen6(cfg.target[c]);
      // quotient truncated toward zero, so the sign is applied after
      blended = in_data.ch[c].neg ? (in_data.ch[c].orig - in_data.ch[c].wrk)
                                  : (in_data.ch[c].orig + in_data.ch[c].wrk);
      if (in_data.fin) begin
        res[c] = tgt;
      end else if (in_data.hit) begin
        res[c] = blended;
      end else begin
        res[c] = in_data.ch[c].orig;
      end
    end
    data_nxt.out_index = in_data.idx;
    data_nxt.new_red   = res[0];
    data_nxt.new_green = res[1];
    data_nxt.new_blue  = res[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/palette_fade_interpolator.sv
// Linear palette fade: one palette entry per transaction in, one faded entry out.
// Entries inside [first_index, last_index] move from their original color toward
// the target by step_number/step_count; once step_number reaches step_count every
// entry takes the target color. The pipeline has one stage for the difference
// and 8x8 multiply, four stages of a restoring divider that resolve two quotient
// bits each, and one output stage for sign, add and select. Every stage has its
// own valid bit and ready, so a new entry is taken each cycle while the output is
// ready, and a stalled output only backs up the stages behind it. Configuration
// registers sit on an APB port at byte addresses 0x00..0x14 and must be written
// only while no transaction is in flight.
`default_nettype none
module palette_fade_interpolator
  import pfi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t      cfg;
  logic      [DIV_STAGES:0] stg_valid;
  logic      [DIV_STAGES:0] stg_ready;
  div_item_t [DIV_STAGES:0] stg_data;

  pfi_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pfi_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    pfi_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (cfg.step_count),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .in_data   (stg_data[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .out_data  (stg_data[k+1])
    );
  end

  pfi_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (stg_valid[DIV_STAGES]),
    .in_ready  (stg_ready[DIV_STAGES]),
    .in_data   (stg_data[DIV_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: test/tb_palette_fade_interpolator.sv
`default_nettype none
module tb_palette_fade_interpolator;
  import pfi_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic [2:0]  REG_UNUSED   = 3'd6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // mirror of the fade registers, reset values
  logic [5:0] tgt_red = 6'd0;
  logic [5:0] tgt_green = 6'd0;
  logic [5:0] tgt_blue = 6'd0;
  logic [7:0] range_lo = 8'd0;
  logic [7:0] range_hi = 8'd255;
  logic [7:0] fade_steps = 8'd1;

  in_item_t    pending_entries[$];
  out_item_t   expected_colors[$];
  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 54;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  palette_fade_interpolator DUT (.*);

  always #6 clk = ~clk;

  function automatic logic [7:0] widen_target(input logic [5:0] v);
    return 8'(int'(v) * 255 / 63);
  endfunction

  // signed division truncates toward zero
  function automatic logic [7:0] fade_channel(input logic [7:0] orig, input logic [7:0] tgt,
                                              input logic [7:0] step, input logic [7:0] steps);
    int delta;
    int part;
    delta = int'(tgt) - int'(orig);
    part = delta * int'(step) / int'(steps);
    return 8'(int'(orig) + part);
  endfunction

  function automatic out_item_t predict_faded_entry(input in_item_t e);
    out_item_t  res;
    logic [7:0] tr, tg, tb;
    tr = widen_target(tgt_red);
    tg = widen_target(tgt_green);
    tb = widen_target(tgt_blue);
    res.out_index = e.entry_index;
    if (e.step_number >= fade_steps) begin
      res.new_red = tr;
      res.new_green = tg;
      res.new_blue = tb;
    end else if (e.entry_index >= range_lo && e.entry_index <= range_hi) begin
      res.new_red = fade_channel(e.orig_red, tr, e.step_number, fade_steps);
      res.new_green = fade_channel(e.orig_green, tg, e.step_number, fade_steps);
      res.new_blue = fade_channel(e.orig_blue, tb, e.step_number, fade_steps);
    end else begin
      res.new_red = e.orig_red;
      res.new_green = e.orig_green;
      res.new_blue = e.orig_blue;
    end
    return res;
  endfunction

  // driver: prediction is queued when an entry is loaded, config is stable then
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_entries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_entries[0];
        expected_colors.push_back(predict_faded_entry(pending_entries[0]));
        void'(pending_entries.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected transaction, out_index %0d", out_data.out_index);
          err_count++;
        end else begin
          want = expected_colors.pop_front();
          if (out_data.out_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, out_data.out_index);
            err_count++;
          end
          if (out_data.new_red !== want.new_red) begin
            $error("new_red: expected %0d, got %0d", want.new_red, out_data.new_red);
            err_count++;
          end
          if (out_data.new_green !== want.new_green) begin
            $error("new_green: expected %0d, got %0d", want.new_green, out_data.new_green);
            err_count++;
          end
          if (out_data.new_blue !== want.new_blue) begin
            $error("new_blue: expected %0d, got %0d", want.new_blue, out_data.new_blue);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_palette_fade_interpolator failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] reg_sel, input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (reg_sel)
      REG_TARGET_RED:   tgt_red = value[5:0];
      REG_TARGET_GREEN: tgt_green = value[5:0];
      REG_TARGET_BLUE:  tgt_blue = value[5:0];
      REG_FIRST_INDEX:  range_lo = value;
      REG_LAST_INDEX:   range_hi = value;
      REG_STEP_COUNT:   fade_steps = value;
      default: ;
    endcase
  endtask

  task automatic set_fade(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic [7:0] lo, input logic [7:0] hi,
                          input logic [7:0] steps);
    write_reg(REG_TARGET_RED, r);
    write_reg(REG_TARGET_GREEN, g);
    write_reg(REG_TARGET_BLUE, b);
    write_reg(REG_FIRST_INDEX, lo);
    write_reg(REG_LAST_INDEX, hi);
    write_reg(REG_STEP_COUNT, steps);
  endtask

  task automatic add_entry(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] step);
    pending_entries.push_back({idx, r, g, b, step});
  endtask

  task automatic wait_idle();
    while (pending_entries.size() != 0 || expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    logic [7:0] a, b, steps;
    a = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    case ($urandom_range(4))
      0: steps = 8'd0;
      1: steps = 8'd1;
      2: steps = 8'd255;
      default: steps = 8'($urandom_range(32, 2));
    endcase
    case ($urandom_range(3))
      0: begin
        a = 8'd0;
        b = 8'd255;
      end
      1: if (a > b) {a, b} = {b, a};
      2: b = a;
      default: ;  // may leave the range empty
    endcase
    set_fade(8'($urandom_range(63)), 8'($urandom_range(63)), 8'($urandom_range(63)),
             a, b, steps);
  endtask

  task automatic random_entries(input int unsigned n);
    logic [7:0] idx, step;
    for (int unsigned i = 0; i < n; i++) begin
      idx = 8'($urandom_range(255));
      if (range_lo <= range_hi && $urandom_range(1) == 0)
        idx = 8'($urandom_range(range_hi, range_lo));
      if (fade_steps != 0 && $urandom_range(3) != 0)
        step = 8'($urandom_range(fade_steps - 1));
      else
        step = 8'($urandom_range(255));
      add_entry(idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), step);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: full range, one step, black target
    add_entry(8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    add_entry(8'd255, 8'd0, 8'd128, 8'd255, 8'd1);
    add_entry(8'd77, 8'd1, 8'd2, 8'd3, 8'd255);
    wait_idle();

    // write to an address past the register list must change nothing
    write_reg(REG_UNUSED, 8'hFF);
    add_entry(8'd7, 8'd10, 8'd20, 8'd30, 8'd0);
    add_entry(8'd8, 8'd10, 8'd20, 8'd30, 8'd1);
    wait_idle();

    set_fade(8'd63, 8'd63, 8'd63, 8'd0, 8'd255, 8'd255);
    add_entry(8'd0, 8'd0, 8'd0, 8'd0, 8'd254);
    add_entry(8'd255, 8'd255, 8'd128, 8'd0, 8'd128);
    add_entry(8'd128, 8'd0, 8'd255, 8'd1, 8'd255);
    wait_idle();

    // widening boundaries at 20, 21 and 42, range edges
    set_fade(8'd21, 8'd42, 8'd20, 8'd10, 8'd20, 8'd7);
    add_entry(8'd9, 8'd200, 8'd10, 8'd100, 8'd3);
    add_entry(8'd10, 8'd200, 8'd10, 8'd100, 8'd3);
    add_entry(8'd20, 8'd0, 8'd255, 8'd77, 8'd6);
    add_entry(8'd21, 8'd0, 8'd255, 8'd77, 8'd3);
    add_entry(8'd21, 8'd0, 8'd255, 8'd77, 8'd7);
    wait_idle();

    // zero step count: everything goes straight to the target
    set_fade(8'd5, 8'd0, 8'd63, 8'd0, 8'd255, 8'd0);
    add_entry(8'd5, 8'd1, 8'd2, 8'd3, 8'd0);
    add_entry(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    wait_idle();

    // empty range: intermediate frames pass through, final frame still fills
    set_fade(8'd63, 8'd0, 8'd32, 8'd200, 8'd100, 8'd4);
    add_entry(8'd150, 8'd90, 8'd91, 8'd92, 8'd2);
    add_entry(8'd0, 8'd255, 8'd0, 8'd255, 8'd3);
    add_entry(8'd250, 8'd12, 8'd34, 8'd56, 8'd4);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        random_setup();
        random_entries(42);
        wait_idle();
      end
    end

    if (err_count == 0)
      $display("tb_palette_fade_interpolator passed");
    else
      $display("tb_palette_fade_interpolator failed");
    $finish;
  end

endmodule
`default_nettype wire
